### rtl/core/futd_pkg.sv
// Package with the types and constants of the font unicode table decoder.
package futd_pkg;

    localparam logic [7:0] GLYPH_SEP_BYTE = 8'hFF;
    localparam logic [1:0] PEND_NONE      = 2'd0;
    localparam logic [1:0] PEND_ONE       = 2'd1;
    localparam logic [1:0] PEND_TWO       = 2'd2;
    localparam logic [1:0] PEND_THREE     = 2'd3;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] code_point;
        logic [15:0] glyph_index;
        logic        table_done;
    } t_out_item;

    typedef struct packed {
        logic [15:0] glyph_counter;
        logic [15:0] partial_code;
        logic [1:0]  bytes_pending;
    } t_dec_state;

endpackage

### rtl/core/futd_decode.sv
// Combinational decode of one table byte against the current decoder state.
module futd_decode
    import futd_pkg::*;
(
    input  t_in_item   i_item,
    input  t_dec_state i_state,
    output t_dec_state o_state,
    output logic       o_emit,
    output t_out_item  o_result
);

    logic [7:0]  b;
    logic [15:0] cp;
    t_dec_state  upd;

    assign b = i_item.table_byte;

    always_comb begin
        upd    = i_state;
        cp     = 16'd0;
        o_emit = 1'b0;
        if (i_state.bytes_pending != PEND_NONE) begin
            // Continuation bytes are taken without checking their top bits.
            upd.partial_code  = {i_state.partial_code[9:0], b[5:0]};
            upd.bytes_pending = i_state.bytes_pending - 2'd1;
            if (i_state.bytes_pending == PEND_ONE) begin
                cp     = upd.partial_code;
                o_emit = 1'b1;
            end
        end else if (b == GLYPH_SEP_BYTE) begin
            upd.glyph_counter = i_state.glyph_counter + 16'd1;
        end else if (!b[7]) begin
            cp     = {8'd0, b};
            o_emit = 1'b1;
        end else if (!b[5]) begin
            upd.partial_code  = {11'd0, b[4:0]};
            upd.bytes_pending = PEND_ONE;
        end else if (!b[4]) begin
            upd.partial_code  = {12'd0, b[3:0]};
            upd.bytes_pending = PEND_TWO;
        end else if (!b[3]) begin
            upd.partial_code  = {13'd0, b[2:0]};
            upd.bytes_pending = PEND_THREE;
        end else begin
            // Bytes 0xB8 to 0xBF and 0xF8 to 0xFE yield code point zero.
            cp     = 16'd0;
            o_emit = 1'b1;
        end

        if (i_item.last_byte) begin
            o_state = '0;
        end else begin
            o_state = upd;
        end

        o_result.code_point  = cp;
        o_result.glyph_index = i_state.glyph_counter;
        o_result.table_done  = i_item.last_byte;
    end

endmodule

### rtl/core/font_unicode_table_decoder_unit.sv
// Font unicode table decoder: turns table bytes into code point and glyph pairs.
//
// Input channel: one table byte per transfer, with a flag on the final byte.
// Output channel: one pair of code point and glyph index per completed code
// point; bytes that only advance the glyph counter or start or continue a sequence
// give no output transfer. Both channels use valid and stall.
// A byte is held in an input register, decoded combinationally against the glyph
// counter and partial code point, and the result lands in an output register.
// One byte is taken every cycle as long as the output side keeps up.
// The byte marked last returns the glyph counter and partial code point to
// zero once it is decoded.
// Synchronous active-low reset empties both registers and clears the state.
// When the receiver stalls with a result waiting, the input register still
// drains bytes that give no result; a byte that would give one waits, and the
// input stalls only while the input register is occupied by such a byte.
module font_unicode_table_decoder_unit
    import futd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    t_dec_state r_state;

    t_dec_state n_state;
    logic       dec_emit;
    t_out_item  dec_result;
    logic       out_free;
    logic       consume;
    logic       in_take;

    futd_decode u_decode (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_emit   (dec_emit),
        .o_result (dec_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    // A byte leaves the input register when it yields nothing or the output
    // register can take its result.
    assign consume    = r_in_valid && (!dec_emit || out_free);
    assign o_in_stall = r_in_valid && !consume;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume && dec_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (consume) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (consume && dec_emit) begin
            r_out <= dec_result;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in.last_byte) |=> (r_state == '0))
        else $error("decoder state not cleared after the last table byte");

    a_seq_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_state.bytes_pending == PEND_ONE) |=> o_out_valid)
        else $error("completed sequence produced no output transfer");

    a_glyph_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && !r_in.last_byte && r_state.bytes_pending == PEND_NONE
         && r_in.table_byte == GLYPH_SEP_BYTE)
        |=> (r_state.glyph_counter == $past(r_state.glyph_counter) + 16'd1))
        else $error("glyph counter did not advance on a separator byte");

    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(consume && dec_emit)) |=> !o_out_valid)
        else $error("output valid raised without a decoded result");

endmodule
